>>> rtl/fifo_queue_with_delete_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the queue with delete
// Shared property forms used by the checker module.
// ---------------------------------------------------------------------------
`ifndef FIFO_QUEUE_WITH_DELETE_MACROS_SVH
`define FIFO_QUEUE_WITH_DELETE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define FQD_ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("queue check failed: same-cycle rule");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define FQD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("queue check failed: next-cycle rule");

`endif

>>> rtl/fqd_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Queue with delete: shared definitions
// Operation and status codes, default sizes and the per-cell control struct.
// ---------------------------------------------------------------------------
package fqd_pkg;

	localparam int DEPTH_DEF      = 16;
	localparam int ITEM_WIDTH_DEF = 32;

	typedef enum logic [1:0] {
		OP_ENQ = 2'd0,
		OP_DEQ = 2'd1,
		OP_DEL = 2'd2,
		OP_NOP = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_NO_MATCH = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	// Commands broadcast to every cell in the cycle a request is taken.
	typedef struct packed {
		logic enq;  // append, only when the queue is not full
		logic deq;  // pop the head, only when the queue is not empty
		logic del;  // remove the first entry equal to the item
	} cell_ctrl_t;

endpackage

>>> rtl/fqd_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Queue with delete: storage cell
// Holds one entry and its valid bit, compares it and shifts toward the head.
// ---------------------------------------------------------------------------
module fqd_cell #(
	parameter int ITEM_WIDTH = fqd_pkg::ITEM_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  fqd_pkg::cell_ctrl_t    ctrl,
	input  logic [ITEM_WIDTH-1:0]  item,
	input  logic                   prev_valid,
	input  logic                   next_valid,
	input  logic [ITEM_WIDTH-1:0]  next_data,
	input  logic                   hit_in,
	output logic                   hit_out,
	output logic                   valid,
	output logic [ITEM_WIDTH-1:0]  data
);

	logic                  valid_q;
	logic [ITEM_WIDTH-1:0] data_q;
	logic                  match;
	logic                  shift;
	logic                  load;

	// A cell shifts once it lies at or behind the first matching entry.
	assign match   = ctrl.del & valid_q & (data_q == item);
	assign hit_out = hit_in | match;
	assign shift   = ctrl.deq | (ctrl.del & hit_out);
	assign load    = ctrl.enq & ~valid_q & prev_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= next_valid;
		end else if (load) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			data_q <= next_data;
		end else if (load) begin
			data_q <= item;
		end
	end

	assign valid = valid_q;
	assign data  = data_q;

endmodule

>>> rtl/fifo_queue_with_delete.sv
`timescale 1ns / 1ps
// The result of a request is registered as the request is taken and held on m_tdata until accepted.
// Throughput: one request per cycle while the result side keeps taking results.
// The figure is set by the row of cells, which compare and shift in the cycle a request is taken.
// Reset (arst_n low) empties the queue at once; no clearing pass is needed.
// Entry words hold no reset value; only valid entries are ever read.
// ---------------------------------------------------------------------------
// Queue with delete: top level
// Bounded FIFO of item words with enqueue, dequeue and delete by value.
// ---------------------------------------------------------------------------
module fifo_queue_with_delete #(
	parameter int DEPTH      = fqd_pkg::DEPTH_DEF,
	parameter int ITEM_WIDTH = fqd_pkg::ITEM_WIDTH_DEF,
	localparam int CNT_W     = $clog2(DEPTH + 1),
	localparam int IN_W      = ((ITEM_WIDTH + 7) / 8) * 8,
	localparam int OUT_W     = ((ITEM_WIDTH + CNT_W + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	// Request side.
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,   // [ITEM_WIDTH-1:0] item_in, rest zero
	input  logic [1:0]       s_tuser,   // [1:0] operation
	// Result side.
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata,   // item_out, then entry_count, rest zero
	output logic [1:0]       m_tuser    // [1:0] status
);

	// The queue is a row of cells with cell 0 at the head. Valid cells always
	// form an unbroken run from the head, so the tail is the first empty cell
	// behind a valid one. Dequeue shifts the whole row by one place; delete
	// shifts only the cells at and behind the first match, which closes the gap
	// and keeps the order. The match flag ripples from head to tail.

	fqd_pkg::cell_ctrl_t   ctrl;
	fqd_pkg::op_t          op;
	fqd_pkg::status_t      status;
	logic                  accept;
	logic                  full;
	logic                  empty;
	logic [ITEM_WIDTH-1:0] item;
	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      count_next;

	logic [DEPTH-1:0]      cell_valid;
	logic [ITEM_WIDTH-1:0] cell_data [DEPTH];
	logic [DEPTH:0]        hit;

	logic                  out_valid_q;
	fqd_pkg::status_t      res_status_q;
	logic [ITEM_WIDTH-1:0] res_item_q;
	logic [CNT_W-1:0]      res_count_q;

	// A new request is taken whenever the result register is free or is
	// being emptied in the same cycle.
	assign s_tready = ~out_valid_q | m_tready;
	assign accept   = s_tvalid & s_tready;

	assign op    = fqd_pkg::op_t'(s_tuser);
	assign item  = s_tdata[ITEM_WIDTH-1:0];
	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);

	assign ctrl.enq = accept & (op == fqd_pkg::OP_ENQ) & ~full;
	assign ctrl.deq = accept & (op == fqd_pkg::OP_DEQ) & ~empty;
	assign ctrl.del = accept & (op == fqd_pkg::OP_DEL);

	assign hit[0] = 1'b0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                  prev_v;
		logic                  next_v;
		logic [ITEM_WIDTH-1:0] next_d;

		if (i == 0) begin : g_head
			assign prev_v = 1'b1;
		end else begin : g_body
			assign prev_v = cell_valid[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign next_v = 1'b0;
			assign next_d = '0;
		end else begin : g_inner
			assign next_v = cell_valid[i+1];
			assign next_d = cell_data[i+1];
		end

		fqd_cell #(
			.ITEM_WIDTH (ITEM_WIDTH)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.item       (item),
			.prev_valid (prev_v),
			.next_valid (next_v),
			.next_data  (next_d),
			.hit_in     (hit[i]),
			.hit_out    (hit[i+1]),
			.valid      (cell_valid[i]),
			.data       (cell_data[i])
		);
	end

	// Status and new entry count for the request being taken.
	always_comb begin
		status     = fqd_pkg::ST_OK;
		count_next = count_q;
		unique case (op)
			fqd_pkg::OP_ENQ: begin
				if (full) begin
					status = fqd_pkg::ST_FULL;
				end else begin
					count_next = count_q + CNT_W'(1);
				end
			end
			fqd_pkg::OP_DEQ: begin
				if (empty) begin
					status = fqd_pkg::ST_EMPTY;
				end else begin
					count_next = count_q - CNT_W'(1);
				end
			end
			fqd_pkg::OP_DEL: begin
				if (hit[DEPTH]) begin
					count_next = count_q - CNT_W'(1);
				end else begin
					status = fqd_pkg::ST_NO_MATCH;
				end
			end
			default: begin
				status = fqd_pkg::ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_next;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload; the head word is returned only by a successful dequeue.
	always_ff @(posedge clk) begin
		if (accept) begin
			res_status_q <= status;
			res_item_q   <= ctrl.deq ? cell_data[0] : '0;
			res_count_q  <= count_next;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = res_status_q;
	assign m_tdata  = OUT_W'({res_count_q, res_item_q});

endmodule

>>> rtl/fqd_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Queue with delete: port checker
// Watches the ports of the top level and checks results against each other.
// ---------------------------------------------------------------------------
`include "fifo_queue_with_delete_macros.svh"

module fqd_checker #(
	parameter int DEPTH      = fqd_pkg::DEPTH_DEF,
	parameter int ITEM_WIDTH = fqd_pkg::ITEM_WIDTH_DEF,
	localparam int CNT_W     = $clog2(DEPTH + 1),
	localparam int OUT_W     = ((ITEM_WIDTH + CNT_W + 7) / 8) * 8
) (
	input logic             clk,
	input logic             arst_n,
	input logic             s_tvalid,
	input logic             s_tready,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata,
	input logic [1:0]       m_tuser
);

	logic [CNT_W-1:0]      cnt;
	logic [ITEM_WIDTH-1:0] item_out;
	logic                  in_acc;

	assign cnt      = m_tdata[ITEM_WIDTH +: CNT_W];
	assign item_out = m_tdata[ITEM_WIDTH-1:0];
	assign in_acc   = s_tvalid & s_tready;

	// An empty result means the queue was and stays empty; a full one means it is full.
	`FQD_ASSERT_IMPLY(a_empty_count, m_tvalid && (m_tuser == fqd_pkg::ST_EMPTY), cnt == '0)
	`FQD_ASSERT_IMPLY(a_full_count, m_tvalid && (m_tuser == fqd_pkg::ST_FULL), cnt == CNT_W'(DEPTH))
	// Only a successful dequeue returns a word.
	`FQD_ASSERT_IMPLY(a_item_zero, m_tvalid && (m_tuser != fqd_pkg::ST_OK), item_out == '0)
	// Every taken request shows a result in the next cycle.
	`FQD_ASSERT_NEXT(a_result_follows, in_acc, m_tvalid)
	// A held result keeps its payload.
	`FQD_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

bind fifo_queue_with_delete fqd_checker #(
	.DEPTH      (DEPTH),
	.ITEM_WIDTH (ITEM_WIDTH)
) u_fqd_checker (.*);

>>> test/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Queue with delete: self-checking testbench
// Drives enqueue, dequeue, delete and no-op requests into the queue and
// checks every result against an in-bench model of the entry list or a
// fixed expected result. A short directed table comes first, then random
// traffic that swings between filling and draining, with gaps on both sides.
// ---------------------------------------------------------------------------
module testbench;

	localparam int DEPTH    = fqd_pkg::DEPTH_DEF;
	localparam int ITEM_W   = fqd_pkg::ITEM_WIDTH_DEF;
	localparam int CNT_W    = $clog2(DEPTH + 1);
	localparam int IN_W     = ((ITEM_W + 7) / 8) * 8;
	localparam int OUT_W    = ((ITEM_W + CNT_W + 7) / 8) * 8;
	localparam int N_RANDOM = 500;
	localparam int N_ROWS   = 18;
	localparam int MAX_CYC  = 200000;
	localparam int IDLE_PCT = 21;

	typedef struct {
		fqd_pkg::status_t   status;
		logic [ITEM_W-1:0]  item;
		logic [CNT_W-1:0]   count;
	} outcome_t;

	// One row of the directed table. Rows marked fixed carry their own
	// expected result; the others are checked against the queue model.
	typedef struct packed {
		fqd_pkg::op_t      op;
		logic [ITEM_W-1:0] item;
		logic [4:0]        reps;
		logic              fixed;
		fqd_pkg::status_t  status;
		logic [ITEM_W-1:0] item_out;
		logic [CNT_W-1:0]  count;
	} plan_row_t;

	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata  = '0;
	logic [1:0]        s_tuser  = fqd_pkg::OP_NOP;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [OUT_W-1:0]  m_tdata;
	logic [1:0]        m_tuser;

	logic [ITEM_W-1:0] held_items[$];
	outcome_t          pending_results[$];
	int unsigned       mismatches = 0;
	int unsigned       cycles     = 0;
	bit                steady     = 1'b0;

	plan_row_t plan [N_ROWS] = '{
		'{fqd_pkg::OP_DEQ, 32'h0000_0000, 5'd1,  1'b1, fqd_pkg::ST_EMPTY,    32'h0, 5'd0},
		'{fqd_pkg::OP_DEL, 32'h0000_0000, 5'd1,  1'b1, fqd_pkg::ST_NO_MATCH, 32'h0, 5'd0},
		'{fqd_pkg::OP_ENQ, 32'h0000_0000, 5'd1,  1'b1, fqd_pkg::ST_OK,       32'h0, 5'd1},
		'{fqd_pkg::OP_DEQ, 32'hFFFF_FFFF, 5'd1,  1'b1, fqd_pkg::ST_OK,       32'h0, 5'd0},
		'{fqd_pkg::OP_ENQ, 32'hFFFF_FFFF, 5'd1,  1'b1, fqd_pkg::ST_OK,       32'h0, 5'd1},
		'{fqd_pkg::OP_DEL, 32'hFFFF_FFFF, 5'd1,  1'b1, fqd_pkg::ST_OK,       32'h0, 5'd0},
		// The only entry is gone: nothing stale may be left behind it.
		'{fqd_pkg::OP_DEQ, 32'h0000_0000, 5'd1,  1'b1, fqd_pkg::ST_EMPTY,    32'h0, 5'd0},
		'{fqd_pkg::OP_DEL, 32'hFFFF_FFFF, 5'd1,  1'b1, fqd_pkg::ST_NO_MATCH, 32'h0, 5'd0},
		'{fqd_pkg::OP_ENQ, 32'h1234_5678, 5'd1,  1'b0, fqd_pkg::ST_OK,       32'h0, 5'd0},
		'{fqd_pkg::OP_ENQ, 32'hAAAA_AAAA, 5'd14, 1'b0, fqd_pkg::ST_OK,       32'h0, 5'd0},
		'{fqd_pkg::OP_ENQ, 32'h5555_5555, 5'd1,  1'b0, fqd_pkg::ST_OK,       32'h0, 5'd0},
		'{fqd_pkg::OP_ENQ, 32'hDEAD_BEEF, 5'd1,  1'b1, fqd_pkg::ST_FULL,     32'h0, 5'd16},
		'{fqd_pkg::OP_NOP, 32'hFFFF_FFFF, 5'd1,  1'b1, fqd_pkg::ST_OK,       32'h0, 5'd16},
		'{fqd_pkg::OP_DEL, 32'h5555_5555, 5'd1,  1'b0, fqd_pkg::ST_OK,       32'h0, 5'd0},
		'{fqd_pkg::OP_DEL, 32'hAAAA_AAAA, 5'd1,  1'b0, fqd_pkg::ST_OK,       32'h0, 5'd0},
		'{fqd_pkg::OP_DEL, 32'h1234_5678, 5'd1,  1'b0, fqd_pkg::ST_OK,       32'h0, 5'd0},
		'{fqd_pkg::OP_DEL, 32'h1234_5678, 5'd1,  1'b0, fqd_pkg::ST_OK,       32'h0, 5'd0},
		'{fqd_pkg::OP_DEQ, 32'h0000_0000, 5'd1,  1'b0, fqd_pkg::ST_OK,       32'h0, 5'd0}
	};

	fifo_queue_with_delete u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= MAX_CYC) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Applies one accepted request to the model of the entry list and
	// returns the result the queue should give for it.
	function automatic outcome_t apply_request(fqd_pkg::op_t op, logic [ITEM_W-1:0] item);
		outcome_t res;
		int       hit;
		res.status = fqd_pkg::ST_OK;
		res.item   = '0;
		hit        = -1;
		case (op)
			fqd_pkg::OP_ENQ: begin
				if (held_items.size() >= DEPTH)
					res.status = fqd_pkg::ST_FULL;
				else
					held_items.push_back(item);
			end
			fqd_pkg::OP_DEQ: begin
				if (held_items.size() == 0)
					res.status = fqd_pkg::ST_EMPTY;
				else
					res.item = held_items.pop_front();
			end
			fqd_pkg::OP_DEL: begin
				for (int i = 0; i < held_items.size(); i++) begin
					if (hit < 0 && held_items[i] == item)
						hit = i;
				end
				if (hit < 0)
					res.status = fqd_pkg::ST_NO_MATCH;
				else
					held_items.delete(hit);
			end
			default: ;
		endcase
		res.count = CNT_W'(held_items.size());
		return res;
	endfunction

	// Offers one request, with a random gap in front of it, and records the
	// expected result once the queue takes it. The valid stays high on exit
	// so that back-to-back requests never drop it within one step.
	task automatic send_request(fqd_pkg::op_t op, logic [ITEM_W-1:0] item, bit fixed,
	                            outcome_t fixed_res);
		outcome_t predicted;
		while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= IN_W'(item);
		do
			@(posedge clk);
		while (!s_tready);
		predicted = apply_request(op, item);
		pending_results.push_back(fixed ? fixed_res : predicted);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	// Result checker: every taken result must match the oldest expectation.
	always @(posedge clk) begin
		outcome_t want;
		logic [ITEM_W-1:0] got_item;
		logic [CNT_W-1:0]  got_count;
		logic [OUT_W-ITEM_W-CNT_W-1:0] got_pad;
		if (arst_n && m_tvalid && m_tready) begin
			got_item  = m_tdata[ITEM_W-1:0];
			got_count = m_tdata[ITEM_W +: CNT_W];
			got_pad   = m_tdata[OUT_W-1:ITEM_W+CNT_W];
			if (pending_results.size() == 0) begin
				mismatches <= mismatches + 1;
				if (mismatches < 10)
					$display("%0t: result with no request waiting: %s %0d item %h count %0d",
					         $realtime, "status", m_tuser, got_item, got_count);
			end else begin
				want = pending_results.pop_front();
				if (m_tuser !== want.status || got_item !== want.item ||
				    got_count !== want.count || got_pad !== '0) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10)
						$display({"%0t: expected status %0d item %h count %0d, ",
						          "got status %0d item %h count %0d pad %h"},
						         $realtime, want.status, want.item, want.count,
						         m_tuser, got_item, got_count, got_pad);
				end
			end
		end
	end

	initial begin
		outcome_t          fixed_res;
		fqd_pkg::op_t      op;
		logic [ITEM_W-1:0] item;
		int unsigned       pick;
		bit                filling;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < N_ROWS; r++) begin
			fixed_res.status = plan[r].status;
			fixed_res.item   = plan[r].item_out;
			fixed_res.count  = plan[r].count;
			for (int k = 0; k < plan[r].reps; k++)
				send_request(plan[r].op, plan[r].item, plan[r].fixed, fixed_res);
		end
		wait_drained();

		// Random part: alternate between phases that lean toward filling and
		// phases that lean toward draining, so both full and empty are hit.
		filling = 1'b1;
		for (int n = 0; n < N_RANDOM; n++) begin
			if (n % 40 == 0)
				filling = $urandom_range(0, 2) != 0 ? ~filling : filling;
			steady <= (n >= 300 && n < 380);
			if (n == 250)
				wait_drained();

			pick = $urandom_range(0, 99);
			if (filling)
				op = pick < 60 ? fqd_pkg::OP_ENQ : pick < 75 ? fqd_pkg::OP_DEQ :
				     pick < 95 ? fqd_pkg::OP_DEL : fqd_pkg::OP_NOP;
			else
				op = pick < 25 ? fqd_pkg::OP_ENQ : pick < 60 ? fqd_pkg::OP_DEQ :
				     pick < 95 ? fqd_pkg::OP_DEL : fqd_pkg::OP_NOP;

			// A small pool of values makes duplicates common; deletes mostly
			// name an entry that is really held, somewhere in the queue.
			pick = $urandom_range(0, 9);
			if (op == fqd_pkg::OP_DEL && held_items.size() != 0 && pick < 7)
				item = held_items[$urandom_range(0, held_items.size() - 1)];
			else if (pick < 4)
				item = ITEM_W'($urandom_range(0, 7));
			else
				item = $urandom;
			send_request(op, item, 1'b0, fixed_res);
		end
		steady <= 1'b0;
		wait_drained();
		repeat (10) @(posedge clk);

		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
